// ----- src/sidb_pkg.sv -----
// Shared types and constants of the signed integer to base digits unit.
// Used by the top level and the testbench; depends on nothing else.
package sidb_pkg;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 32;
	localparam int unsigned RADIX_W     = 5;
	localparam int unsigned VALUE_W     = 32;
	localparam int unsigned CHAR_W      = 8;

	localparam logic [CHAR_W-1:0] SYM_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] SYM_MINUS = 8'h2D;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_RADIX      = 3'd0,
		CFG_SYM_LO     = 3'd1,
		CFG_SYM_MID_LO = 3'd2,
		CFG_SYM_MID_HI = 3'd3,
		CFG_SYM_HI     = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIVIDE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
	} number_item_t;

	typedef struct packed {
		logic [CHAR_W-1:0] text_char;
		logic              is_last;
	} char_item_t;

endpackage

// ----- src/sidb_stream_if.sv -----
// Valid/ready stream channel carrying one item of a given payload type.
// Payload types come from sidb_pkg.
interface sidb_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- src/signed_int_to_base_digits_unit.sv -----
// Signed integer to text in a configurable base, one character per output item.
// Depends on sidb_pkg and sidb_stream_if.

// A number is taken when the unit is idle and leaves as text, most significant
// digit first, with a leading '-' for negative values and is_last on the final
// character. The alphabet (radix and up to MAX_SYMBOLS symbols) is to be written
// through the configuration port only while the unit is idle; the unit itself does
// not enforce this. An item taken with an invalid alphabet yields no output. A
// number with D digits is taken, its alphabet is checked, then it is divided D
// times by the radix on a shared restoring divider that retires eight quotient
// bits a cycle, and its D characters (plus one for the sign) leave through the
// output register at one a cycle when not stalled. The next number is taken as
// soon as its last character sits in the output register.
module signed_int_to_base_digits_unit #(
	parameter int unsigned MAX_SYMBOLS = 16,
	parameter int unsigned VALUE_BITS  = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [sidb_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [sidb_pkg::CFG_DATA_W-1:0]    cfg_data,
	sidb_stream_if.sink                        number,
	sidb_stream_if.source                      text
);

	localparam int unsigned SYM_IW     = $clog2(MAX_SYMBOLS);
	localparam int unsigned STEPS      = 8;
	localparam int unsigned DIV_CYCLES = (VALUE_BITS + STEPS - 1) / STEPS;
	localparam int unsigned DW         = DIV_CYCLES * STEPS;
	localparam int unsigned STEP_W     = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
	localparam int unsigned IDX_W      = $clog2(VALUE_BITS);

	sidb_pkg::state_t state_q, state_d;

	logic [sidb_pkg::RADIX_W-1:0] radix_q;
	logic [sidb_pkg::CHAR_W-1:0]  sym_q [MAX_SYMBOLS];

	logic [SYM_IW-1:0]     dig_store_q [VALUE_BITS];
	logic [DW-1:0]         div_q, div_nx;
	logic [SYM_IW-1:0]     rem_q, rem_nx;
	logic [STEP_W-1:0]     step_q;
	logic [IDX_W-1:0]      dig_idx_q, emit_idx_q;
	logic                  neg_q, sign_q;
	logic                  out_valid_q;
	logic [sidb_pkg::CHAR_W-1:0] out_char_q;
	logic                  out_last_q;

	logic [VALUE_BITS-1:0] raw, mag;
	logic [SYM_IW:0]       radix_div;
	logic                  alpha_ok;
	logic                  last_step, quot_zero, load, emit_done, accept;

	assign raw       = number.data.value[VALUE_BITS-1:0];
	assign mag       = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
	assign radix_div = radix_q[SYM_IW:0];
	assign last_step = (step_q == STEP_W'(DIV_CYCLES - 1));
	assign quot_zero = (div_nx[VALUE_BITS-1:0] == '0);
	assign load      = (state_q == sidb_pkg::ST_EMIT) && (!out_valid_q || text.ready);
	assign emit_done = load && !sign_q && (emit_idx_q == '0);
	assign accept    = number.valid && number.ready;

	// Alphabet check: radix in range, no sign characters, no repeats among the
	// symbols in use.
	always_comb begin
		alpha_ok = (radix_q >= sidb_pkg::RADIX_W'(2))
			&& (radix_q <= sidb_pkg::RADIX_W'(MAX_SYMBOLS));
		for (int i = 0; i < MAX_SYMBOLS; i++) begin
			if (sidb_pkg::RADIX_W'(i) < radix_q) begin
				if (sym_q[i] == sidb_pkg::SYM_PLUS || sym_q[i] == sidb_pkg::SYM_MINUS)
					alpha_ok = 1'b0;
				for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
					if (sidb_pkg::RADIX_W'(j) < radix_q && sym_q[i] == sym_q[j])
						alpha_ok = 1'b0;
				end
			end
		end
	end

	// Eight restoring steps of the shared divider. The dividend shifts out at
	// the top while quotient bits enter at the bottom.
	always_comb begin
		logic [SYM_IW-1:0] r;
		logic [DW-1:0]     d;
		logic [SYM_IW:0]   t;
		r = rem_q;
		d = div_q;
		t = '0;
		for (int i = 0; i < STEPS; i++) begin
			t = {r, d[DW-1]};
			d = {d[DW-2:0], 1'b0};
			if (t >= radix_div) begin
				r    = SYM_IW'(t - radix_div);
				d[0] = 1'b1;
			end else begin
				r = t[SYM_IW-1:0];
			end
		end
		rem_nx = r;
		div_nx = d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sidb_pkg::ST_IDLE: begin
				if (number.valid)
					state_d = sidb_pkg::ST_CHECK;
			end
			sidb_pkg::ST_CHECK: begin
				state_d = alpha_ok ? sidb_pkg::ST_DIVIDE : sidb_pkg::ST_IDLE;
			end
			sidb_pkg::ST_DIVIDE: begin
				if (last_step && quot_zero)
					state_d = sidb_pkg::ST_EMIT;
			end
			sidb_pkg::ST_EMIT: begin
				if (emit_done)
					state_d = sidb_pkg::ST_IDLE;
			end
			default: state_d = sidb_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		number.ready        = (state_q == sidb_pkg::ST_IDLE);
		text.valid          = out_valid_q;
		text.data.text_char = out_char_q;
		text.data.is_last   = out_last_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sidb_pkg::ST_IDLE;
			step_q      <= '0;
			sign_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == sidb_pkg::ST_DIVIDE)
				step_q <= last_step ? '0 : step_q + 1'b1;
			else
				step_q <= '0;
			if (state_q == sidb_pkg::ST_DIVIDE && last_step && quot_zero)
				sign_q <= neg_q;
			else if (load)
				sign_q <= 1'b0;
			if (load)
				out_valid_q <= 1'b1;
			else if (text.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= '0;
			for (int s = 0; s < MAX_SYMBOLS; s++)
				sym_q[s] <= '0;
		end else if (cfg_we) begin
			if (cfg_index == sidb_pkg::CFG_RADIX)
				radix_q <= cfg_data[sidb_pkg::RADIX_W-1:0];
			// Symbols past MAX_SYMBOLS can never be in use and are not kept.
			for (int s = 0; s < MAX_SYMBOLS; s++) begin
				if (cfg_index == sidb_pkg::CFG_INDEX_W'(int'(sidb_pkg::CFG_SYM_LO) + (s >> 2)))
					sym_q[s] <= cfg_data[8 * (s & 3) +: 8];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			div_q     <= DW'(mag);
			rem_q     <= '0;
			neg_q     <= raw[VALUE_BITS-1];
			dig_idx_q <= '0;
		end else if (state_q == sidb_pkg::ST_DIVIDE) begin
			if (last_step) begin
				dig_store_q[dig_idx_q] <= rem_nx;
				if (quot_zero) begin
					emit_idx_q <= dig_idx_q;
				end else begin
					dig_idx_q <= dig_idx_q + 1'b1;
					div_q     <= div_nx;
					rem_q     <= '0;
				end
			end else begin
				div_q <= div_nx;
				rem_q <= rem_nx;
			end
		end
		if (load) begin
			if (sign_q) begin
				out_char_q <= sidb_pkg::SYM_MINUS;
				out_last_q <= 1'b0;
			end else begin
				out_char_q <= sym_q[dig_store_q[emit_idx_q]];
				out_last_q <= (emit_idx_q == '0);
				emit_idx_q <= emit_idx_q - 1'b1;
			end
		end
	end

	// The partial remainder always stays below the radix while dividing.
	a_rem_below_radix: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sidb_pkg::ST_DIVIDE) |-> ({1'b0, rem_q} < radix_div))
		else $error("partial remainder reached the radix");

	// Every digit sent out indexes a symbol that is in use.
	a_digit_in_alphabet: assert property (@(posedge clk) disable iff (!arst_n)
		(load && !sign_q) |->
		(sidb_pkg::RADIX_W'(dig_store_q[emit_idx_q]) < radix_q))
		else $error("emitted digit outside the alphabet");

	// A sign is never the final character of a number.
	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_char_q == sidb_pkg::SYM_MINUS) |-> !out_last_q)
		else $error("minus sign flagged as last character");

	// A rejected alphabet sends the unit straight back to idle with no output.
	a_reject_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sidb_pkg::ST_CHECK && !alpha_ok && !out_valid_q) |=>
		(state_q == sidb_pkg::ST_IDLE && !out_valid_q))
		else $error("item with invalid alphabet produced output");

endmodule

// ----- sim/tb.sv -----
// Testbench for signed_int_to_base_digits_unit: numbers go in, text characters come out.
// Depends on sidb_pkg and sidb_stream_if. It predicts every character from its own copy
// of the alphabet registers and checks each output item against it in order.
`timescale 1ns / 1ps

module tb;

	localparam int unsigned MAX_SYMBOLS  = 16;
	localparam int          DRAIN_CYCLES = 200;
	localparam int          CYCLE_LIMIT  = 1000000;

	typedef enum {RX_STEADY, RX_RANDOM, RX_PATTERN} rx_mode_t;

	logic                             clk;
	logic                             arst_n;
	logic                             cfg_we;
	logic [sidb_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [sidb_pkg::CFG_DATA_W-1:0]  cfg_data;

	sidb_stream_if #(.payload_t(sidb_pkg::number_item_t)) number_ch ();
	sidb_stream_if #(.payload_t(sidb_pkg::char_item_t))   text_ch ();

	signed_int_to_base_digits_unit #(
		.MAX_SYMBOLS(MAX_SYMBOLS),
		.VALUE_BITS(sidb_pkg::VALUE_W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.number(number_ch),
		.text(text_ch)
	);

	// Mirror of the alphabet registers.
	logic [sidb_pkg::RADIX_W-1:0]    alpha_radix;
	logic [sidb_pkg::CFG_DATA_W-1:0] alpha_words [4];

	sidb_pkg::char_item_t expected_chars [$];
	sidb_pkg::char_item_t want_char;
	int         mismatches      = 0;
	int         cycle_count     = 0;
	rx_mode_t   rx_mode         = RX_STEADY;
	int         rx_hold_request = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic logic [sidb_pkg::CHAR_W-1:0] symbol_at(input logic [3:0] k);
		return alpha_words[k[3:2]][k[1:0] * 8 +: 8];
	endfunction

	function automatic bit alphabet_valid();
		logic [sidb_pkg::CHAR_W-1:0] s;
		if (alpha_radix < 2 || alpha_radix > MAX_SYMBOLS)
			return 1'b0;
		for (int i = 0; i < alpha_radix; i++) begin
			s = symbol_at(4'(i));
			if (s == sidb_pkg::SYM_PLUS || s == sidb_pkg::SYM_MINUS)
				return 1'b0;
			for (int j = i + 1; j < alpha_radix; j++)
				if (symbol_at(4'(j)) == s)
					return 1'b0;
		end
		return 1'b1;
	endfunction

	// Queues the characters that the unit must produce for one accepted number.
	function automatic void render_number(input logic signed [sidb_pkg::VALUE_W-1:0] v);
		logic [sidb_pkg::VALUE_W-1:0] mag;
		logic [3:0]                   digits [sidb_pkg::VALUE_W];
		int                           n;
		if (!alphabet_valid())
			return;
		mag = v;
		if (v[sidb_pkg::VALUE_W-1]) begin
			mag = ~mag + 1'b1;
			expected_chars.push_back(sidb_pkg::char_item_t'{
				text_char: sidb_pkg::SYM_MINUS, is_last: 1'b0});
		end
		n = 0;
		do begin
			digits[n] = 4'(mag % alpha_radix);
			n++;
			mag = mag / alpha_radix;
		end while (mag != 0 && n < sidb_pkg::VALUE_W);
		for (int k = n - 1; k >= 0; k--)
			expected_chars.push_back(sidb_pkg::char_item_t'{
				text_char: symbol_at(digits[k]), is_last: (k == 0)});
	endfunction

	always @(posedge clk) begin
		if (arst_n && text_ch.valid && text_ch.ready) begin
			if (expected_chars.size() == 0) begin
				$error("unexpected item: text_char %h is_last %b",
					text_ch.data.text_char, text_ch.data.is_last);
				mismatches++;
			end else begin
				want_char = expected_chars.pop_front();
				if (text_ch.data.text_char !== want_char.text_char) begin
					$error("text_char: expected %h, got %h",
						want_char.text_char, text_ch.data.text_char);
					mismatches++;
				end
				if (text_ch.data.is_last !== want_char.is_last) begin
					$error("is_last: expected %b, got %b",
						want_char.is_last, text_ch.data.is_last);
					mismatches++;
				end
			end
		end
	end

	// Receiver: a long hold-off when asked for, otherwise the current stall pattern.
	initial begin
		int hold_left;
		int run_left;
		bit run_on;
		hold_left = 0;
		run_left = 0;
		run_on = 1'b0;
		text_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_request > 0) begin
				hold_left = rx_hold_request;
				rx_hold_request = 0;
			end
			if (hold_left > 0) begin
				text_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				case (rx_mode)
					RX_STEADY: text_ch.ready <= 1'b1;
					RX_RANDOM: text_ch.ready <= ($urandom_range(0, 3) != 0);
					default: begin
						if (run_left == 0) begin
							run_on = !run_on;
							run_left = run_on ? $urandom_range(1, 12) : $urandom_range(1, 6);
						end
						run_left--;
						text_ch.ready <= run_on;
					end
				endcase
			end
		end
	end

	// Leaves valid high so that items of one burst follow each other without a gap.
	task automatic send_number(input logic signed [sidb_pkg::VALUE_W-1:0] v);
		number_ch.valid <= 1'b1;
		number_ch.data <= sidb_pkg::number_item_t'{value: v};
		do @(posedge clk); while (!number_ch.ready);
		render_number(v);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		number_ch.valid <= 1'b0;
		while (expected_chars.size() != 0)
			@(negedge clk);
		// An item taken with a bad alphabet leaves nothing to wait for, so allow it to settle.
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [sidb_pkg::CFG_INDEX_W-1:0] idx,
			input logic [sidb_pkg::CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		if (idx == sidb_pkg::CFG_RADIX)
			alpha_radix = data[sidb_pkg::RADIX_W-1:0];
		else if (idx >= sidb_pkg::CFG_SYM_LO && idx <= sidb_pkg::CFG_SYM_HI)
			alpha_words[idx - sidb_pkg::CFG_SYM_LO] = data;
	endtask

	task automatic program_alphabet(input logic [sidb_pkg::RADIX_W-1:0] r,
			input logic [sidb_pkg::CHAR_W-1:0] syms [MAX_SYMBOLS]);
		logic [sidb_pkg::CFG_DATA_W-1:0] word;
		word = $urandom();
		word[sidb_pkg::RADIX_W-1:0] = r;
		write_reg(sidb_pkg::CFG_RADIX, word);
		for (int w = 0; w < 4; w++) begin
			word = {syms[4 * w + 3], syms[4 * w + 2], syms[4 * w + 1], syms[4 * w]};
			write_reg(sidb_pkg::cfg_reg_t'(int'(sidb_pkg::CFG_SYM_LO) + w), word);
		end
		// A write to an unused index must change nothing.
		write_reg(sidb_pkg::CFG_INDEX_W'($urandom_range(int'(sidb_pkg::CFG_SYM_HI) + 1,
			(1 << sidb_pkg::CFG_INDEX_W) - 1)), $urandom());
	endtask

	function automatic void fill_decimal(output logic [sidb_pkg::CHAR_W-1:0] syms [MAX_SYMBOLS]);
		for (int i = 0; i < MAX_SYMBOLS; i++)
			syms[i] = (i < 10) ? sidb_pkg::CHAR_W'("0" + i)
				: ((i % 2) ? sidb_pkg::SYM_PLUS : sidb_pkg::SYM_MINUS);
	endfunction

	function automatic void pick_alphabet(output logic [sidb_pkg::RADIX_W-1:0] r,
			output logic [sidb_pkg::CHAR_W-1:0] syms [MAX_SYMBOLS], input bit broken,
			input int fixed_radix);
		logic [sidb_pkg::CHAR_W-1:0] s;
		bit                          clash;
		int                          i;
		int                          j;
		r = (fixed_radix != 0) ? sidb_pkg::RADIX_W'(fixed_radix)
			: sidb_pkg::RADIX_W'($urandom_range(2, MAX_SYMBOLS));
		for (i = 0; i < MAX_SYMBOLS; i++) begin
			if (i < r) begin
				do begin
					s = sidb_pkg::CHAR_W'($urandom_range(0, 255));
					clash = (s == sidb_pkg::SYM_PLUS || s == sidb_pkg::SYM_MINUS);
					for (j = 0; j < i; j++)
						if (syms[j] == s)
							clash = 1'b1;
				end while (clash);
			end else begin
				case ($urandom_range(0, 2))
					0: s = sidb_pkg::SYM_PLUS;
					1: s = sidb_pkg::SYM_MINUS;
					default: s = sidb_pkg::CHAR_W'($urandom_range(0, 255));
				endcase
			end
			syms[i] = s;
		end
		if (broken) begin
			case ($urandom_range(0, 3))
				0: r = sidb_pkg::RADIX_W'($urandom_range(0, 1));
				1: r = sidb_pkg::RADIX_W'($urandom_range(MAX_SYMBOLS + 1,
					(1 << sidb_pkg::RADIX_W) - 1));
				2: syms[$urandom_range(0, r - 1)] = $urandom_range(0, 1)
					? sidb_pkg::SYM_PLUS : sidb_pkg::SYM_MINUS;
				default: begin
					i = $urandom_range(0, r - 2);
					j = $urandom_range(i + 1, r - 1);
					syms[j] = syms[i];
				end
			endcase
		end
	endfunction

	function automatic logic signed [sidb_pkg::VALUE_W-1:0] random_value();
		logic [sidb_pkg::VALUE_W-1:0] v;
		case ($urandom_range(0, 4))
			0: v = $urandom();
			1: v = $urandom_range(0, 40);
			2: v = -$urandom_range(1, 40);
			3: begin
				v = $urandom() >> $urandom_range(0, sidb_pkg::VALUE_W - 1);
				if ($urandom_range(0, 1))
					v = -v;
			end
			default: begin
				case ($urandom_range(0, 3))
					0: v = '0;
					1: v = '1;
					2: v = {1'b0, {(sidb_pkg::VALUE_W - 1){1'b1}}};
					default: v = {1'b1, {(sidb_pkg::VALUE_W - 1){1'b0}}};
				endcase
			end
		endcase
		return v;
	endfunction

	task automatic send_stream(input int count, input bit gappy);
		int sent;
		int burst;
		int gap;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 8);
			for (int i = 0; i < burst && sent < count; i++) begin
				send_number(random_value());
				sent++;
			end
			gap = gappy ? $urandom_range(0, 6) : 0;
			if (gap > 0) begin
				number_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	endtask

	// Out of reset the radix is zero, so numbers must vanish.
	task automatic test_unconfigured();
		rx_mode = RX_STEADY;
		send_number(0);
		send_number(-1);
		wait_idle();
	endtask

	task automatic test_decimal_extremes();
		logic [sidb_pkg::CHAR_W-1:0] syms [MAX_SYMBOLS];
		fill_decimal(syms);
		program_alphabet(10, syms);
		send_number(0);
		send_number(7);
		send_number(-1);
		send_number(10);
		send_number(-10);
		send_number(32'sh7FFFFFFF);
		send_number(32'sh80000000);
		send_number(32'sh80000001);
		wait_idle();
	endtask

	// Binary gives the longest text; zero and all-ones bytes serve as symbols.
	task automatic test_binary_extremes();
		logic [sidb_pkg::CHAR_W-1:0] syms [MAX_SYMBOLS];
		for (int i = 0; i < MAX_SYMBOLS; i++)
			syms[i] = sidb_pkg::SYM_MINUS;
		syms[0] = 8'h00;
		syms[1] = 8'hFF;
		rx_mode = RX_RANDOM;
		program_alphabet(2, syms);
		send_number(32'sh80000000);
		send_number(32'sh7FFFFFFF);
		send_number(0);
		send_number(-1);
		wait_idle();
	endtask

	task automatic test_full_alphabet();
		logic [sidb_pkg::CHAR_W-1:0] syms [MAX_SYMBOLS];
		for (int i = 0; i < MAX_SYMBOLS; i++)
			syms[i] = (i < 10) ? sidb_pkg::CHAR_W'("0" + i) : sidb_pkg::CHAR_W'("a" + i - 10);
		syms[15] = 8'h00;
		rx_mode = RX_PATTERN;
		program_alphabet(sidb_pkg::RADIX_W'(MAX_SYMBOLS), syms);
		send_number(32'sh80000000);
		send_number(32'shDEADBEEF);
		send_number(32'sh7FFFFFFF);
		send_number(15);
		wait_idle();
	endtask

	task automatic test_bad_alphabets();
		logic [sidb_pkg::CHAR_W-1:0] syms [MAX_SYMBOLS];
		rx_mode = RX_STEADY;
		fill_decimal(syms);
		program_alphabet(1, syms);
		send_number(5);
		wait_idle();
		program_alphabet(sidb_pkg::RADIX_W'(MAX_SYMBOLS + 1), syms);
		send_number(-5);
		wait_idle();
		program_alphabet(sidb_pkg::RADIX_W'((1 << sidb_pkg::RADIX_W) - 1), syms);
		send_number(123);
		wait_idle();
		syms[3] = sidb_pkg::SYM_PLUS;
		program_alphabet(10, syms);
		send_number(-42);
		wait_idle();
		fill_decimal(syms);
		syms[9] = sidb_pkg::SYM_MINUS;
		program_alphabet(10, syms);
		send_number(99);
		wait_idle();
		syms[9] = syms[0];
		program_alphabet(10, syms);
		send_number(1000);
		wait_idle();
		// A sign just past the end of the alphabet is harmless.
		fill_decimal(syms);
		syms[10] = sidb_pkg::SYM_MINUS;
		program_alphabet(10, syms);
		send_number(-90);
		wait_idle();
	endtask

	task automatic test_random_alphabets();
		logic [sidb_pkg::RADIX_W-1:0] r;
		logic [sidb_pkg::CHAR_W-1:0]  syms [MAX_SYMBOLS];
		bit                           broken;
		for (int phase = 0; phase < 12; phase++) begin
			broken = (phase % 4 == 3);
			pick_alphabet(r, syms, broken, (phase == 0) ? 2 : ((phase == 1) ? MAX_SYMBOLS : 0));
			wait_idle();
			program_alphabet(r, syms);
			rx_mode = rx_mode_t'($urandom_range(0, 2));
			send_stream(broken ? 3 : 20, $urandom_range(0, 3) != 0);
		end
		wait_idle();
	endtask

	// The receiver holds off while numbers keep coming, so the unit must stall its input.
	task automatic test_backpressure();
		logic [sidb_pkg::CHAR_W-1:0] syms [MAX_SYMBOLS];
		fill_decimal(syms);
		program_alphabet(10, syms);
		rx_mode = RX_PATTERN;
		rx_hold_request = 600;
		send_stream(30, 1'b0);
		wait_idle();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		number_ch.valid = 1'b0;
		number_ch.data = '0;
		alpha_radix = '0;
		for (int w = 0; w < 4; w++)
			alpha_words[w] = '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_unconfigured();
		test_decimal_extremes();
		test_binary_extremes();
		test_full_alphabet();
		test_bad_alphabets();
		test_random_alphabets();
		test_backpressure();
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
